>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL of the field step engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that prop holds at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that prop holds at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> rtl/core/fdtd_pkg.sv
// -----------------------------------------------------------------------------
// fdtd_pkg: shared constants, types and arithmetic of the field step engine
// Grid geometry, request codes, coefficient scaling and saturation helpers.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package fdtd_pkg;
  localparam int GRID_X = 64;
  localparam int GRID_Y = 64;
  localparam int NCELLS = GRID_X * GRID_Y;
  localparam int XW = $clog2(GRID_X);
  localparam int YW = $clog2(GRID_Y);
  localparam int AW = $clog2(NCELLS);
  localparam int CW = 48;
  localparam int DW = 32;

  localparam logic [1:0] REQ_WR_FIELD = 2'd0;
  localparam logic [1:0] REQ_WR_CUR   = 2'd1;
  localparam logic [1:0] REQ_STEP     = 2'd2;
  localparam logic [1:0] REQ_READ     = 2'd3;

  localparam logic [2:0] CFG_H_X = 3'd0;
  localparam logic [2:0] CFG_H_Y = 3'd1;
  localparam logic [2:0] CFG_E_X = 3'd2;
  localparam logic [2:0] CFG_E_Y = 3'd3;
  localparam logic [2:0] CFG_SRC = 3'd4;

  // Magnitude product pieces: 33-bit magnitude times 24-bit halves
  typedef logic [56:0] prod_t;
  typedef logic signed [58:0] term_t;

  // Combine the two partial products into a rounded signed term
  function automatic term_t cterm_fin(input prod_t p_hi, input prod_t p_lo,
                                      input logic neg);
    logic [57:0] lo_r;
    logic [58:0] r;
    begin
      lo_r = {1'b0, p_lo} + 58'h800000;
      r = {2'b00, p_hi} + {25'd0, lo_r[57:24]};
      cterm_fin = neg ? -$signed(r) : $signed(r);
    end
  endfunction

  // Saturate a wide signed sum to Q16.16
  function automatic logic [DW:0] sat32(input logic signed [60:0] v);
    begin
      if (v > 61'sd2147483647) sat32 = {1'b1, 32'h7fffffff};
      else if (v < -61'sd2147483648) sat32 = {1'b1, 32'h80000000};
      else sat32 = {1'b0, v[DW-1:0]};
    end
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/fdtd_cell.sv
// -----------------------------------------------------------------------------
// fdtd_cell: one pipelined update cell of the sweep chain
// Forms c_a*d_a, c_b*d_b over stages, rounds, adds to base (neg_b negates b).
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fdtd_cell (
  input  wire logic                 clk,
  input  wire logic                 vld_in,
  input  wire logic [fdtd_pkg::AW-1:0] addr_in,
  input  wire logic signed [31:0]   base_in,
  input  wire logic signed [32:0]   d_a,
  input  wire logic signed [32:0]   d_b,
  input  wire logic [47:0]          c_a,
  input  wire logic [47:0]          c_b,
  input  wire logic                 neg_b,
  output logic                      vld_out,
  output logic [fdtd_pkg::AW-1:0]   addr_out,
  output logic signed [31:0]        val_out,
  output logic                      sat_out
);
  // stage 1: magnitudes
  logic [32:0] ma_r, mb_r;
  logic na_r, nb_r, v1_r;
  logic [fdtd_pkg::AW-1:0] a1_r;
  logic signed [31:0] b1_r;
  // stage 2: partial products
  fdtd_pkg::prod_t pah_r, pal_r, pbh_r, pbl_r;
  logic na2_r, nb2_r, v2_r;
  logic [fdtd_pkg::AW-1:0] a2_r;
  logic signed [31:0] b2_r;
  // stage 3: terms
  fdtd_pkg::term_t ta_r, tb_r;
  logic v3_r;
  logic [fdtd_pkg::AW-1:0] a3_r;
  logic signed [31:0] b3_r;
  logic signed [60:0] sum;
  logic [32:0] sv;

  always_ff @(posedge clk) begin
    v1_r <= vld_in; a1_r <= addr_in; b1_r <= base_in;
    na_r <= d_a[32]; nb_r <= d_b[32] ^ neg_b;
    ma_r <= d_a[32] ? 33'(-d_a) : 33'(d_a);
    mb_r <= d_b[32] ? 33'(-d_b) : 33'(d_b);
    v2_r <= v1_r; a2_r <= a1_r; b2_r <= b1_r; na2_r <= na_r; nb2_r <= nb_r;
    pah_r <= ma_r * c_a[47:24]; pal_r <= ma_r * c_a[23:0];
    pbh_r <= mb_r * c_b[47:24]; pbl_r <= mb_r * c_b[23:0];
    v3_r <= v2_r; a3_r <= a2_r; b3_r <= b2_r;
    ta_r <= fdtd_pkg::cterm_fin(pah_r, pal_r, na2_r);
    tb_r <= fdtd_pkg::cterm_fin(pbh_r, pbl_r, nb2_r);
  end

  // add and saturate
  always_comb begin
    sum = 61'(b3_r) + 61'(ta_r) + 61'(tb_r);
    sv = fdtd_pkg::sat32(sum);
  end
  assign vld_out = v3_r;
  assign addr_out = a3_r;
  assign val_out = sv[31:0];
  assign sat_out = sv[32] & v3_r;
endmodule
`default_nettype wire

>>> rtl/core/fdtd_2d_te_field_step.sv
// -----------------------------------------------------------------------------
// fdtd_2d_te_field_step: 2D TE Yee grid field engine
// channel | direction | handshake
// in_     | in        | start & !busy
// out_    | out       | out_valid strobe, one cycle
// cfg_    | in        | cfg_valid & cfg_ready
// Writes complete in idle; a read passes through S_RD. A step runs an H sweep
// then an E sweep, each one cell a cycle through a 3-stage multiply cell plus a
// drain of the read and cell stages; the result is strobed from S_DONE.
// Grids clear by a pass over every cell after reset, busy high meanwhile.
// The receiver cannot stall; results are strobed once.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fdtd_2d_te_field_step (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [5:0]  in_cell_x,
  input  wire logic [5:0]  in_cell_y,
  input  wire logic signed [31:0] in_ex_in,
  input  wire logic signed [31:0] in_ey_in,
  input  wire logic signed [31:0] in_hz_in,
  input  wire logic signed [31:0] in_jx_in,
  input  wire logic signed [31:0] in_jy_in,
  output logic             out_valid,
  output logic             out_result_kind,
  output logic signed [31:0] out_ex_out,
  output logic signed [31:0] out_ey_out,
  output logic signed [31:0] out_hz_out,
  output logic             out_saturated,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  localparam int AW = fdtd_pkg::AW;
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2,
                         S_H = 3'd3, S_E = 3'd4, S_DONE = 3'd5;

  logic [2:0] st_r;
  logic [AW:0] cnt_r;
  logic [47:0] chx_r, chy_r, cex_r, cey_r, csrc_r;
  logic sat_r;

  // memories
  logic signed [31:0] ex_m [fdtd_pkg::NCELLS];
  logic signed [31:0] ey_m [fdtd_pkg::NCELLS];
  logic signed [31:0] hz_m [fdtd_pkg::NCELLS];
  logic signed [31:0] jx_m [fdtd_pkg::NCELLS];
  logic signed [31:0] jy_m [fdtd_pkg::NCELLS];

  assign busy = (st_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chx_r <= '0; chy_r <= '0; cex_r <= '0; cey_r <= '0; csrc_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fdtd_pkg::CFG_H_X: chx_r <= cfg_data;
        fdtd_pkg::CFG_H_Y: chy_r <= cfg_data;
        fdtd_pkg::CFG_E_X: cex_r <= cfg_data;
        fdtd_pkg::CFG_E_Y: cey_r <= cfg_data;
        fdtd_pkg::CFG_SRC: csrc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sweep address: index walks a row-major order; x=low bits, y=high bits.
  // Each sweep reads only old values of the other grid plus its own cell,
  // so order does not matter.
  logic [AW-1:0] sa;
  logic [fdtd_pkg::XW-1:0] sx;
  logic [fdtd_pkg::YW-1:0] sy;
  assign sa = cnt_r[AW-1:0];
  assign sx = sa[fdtd_pkg::XW-1:0];
  assign sy = sa[AW-1:fdtd_pkg::XW];
  logic sweep_ok;
  always_comb begin
    if (st_r == S_H)
      sweep_ok = (32'(sx) < fdtd_pkg::GRID_X - 1) && (32'(sy) < fdtd_pkg::GRID_Y - 1);
    else
      sweep_ok = (sx != '0) && (sy != '0);
  end
  logic issue;
  assign issue = ((st_r == S_H) || (st_r == S_E)) && !cnt_r[AW];

  // read port addresses: H sweep reads (c, c+GRID_X for Ex, c+1 for Ey);
  // E sweep reads Hz at c and c-GRID_X
  logic [AW-1:0] a0, an, ax;
  always_comb begin
    a0 = sa;
    if (st_r == S_H) begin
      an = sa + AW'(fdtd_pkg::GRID_X);
      ax = sa + AW'(1);
    end else begin
      an = sa - AW'(fdtd_pkg::GRID_X);
      ax = sa - AW'(1);
    end
    if (st_r == S_RD || st_r == S_IDLE) a0 = {in_cell_y, in_cell_x};
  end

  // registered reads; Hz at c-1 is the Hz at c read for the previous cell,
  // held in hzx_r, since the sweep steps one cell a cycle
  logic signed [31:0] ex0_r, exn_r, ey0_r, eyx_r, hz0_r, hzn_r, hzx_r, jx_r, jy_r;
  logic pv_r;
  logic [AW-1:0] pa_r;
  always_ff @(posedge clk) begin
    ex0_r <= ex_m[a0]; exn_r <= ex_m[an];
    ey0_r <= ey_m[a0]; eyx_r <= ey_m[ax];
    hz0_r <= hz_m[a0]; hzn_r <= hz_m[an]; hzx_r <= hz0_r;
    jx_r <= jx_m[a0]; jy_r <= jy_m[a0];
    pa_r <= sa;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else pv_r <= issue && sweep_ok;
  end
  logic ph_r;
  always_ff @(posedge clk) ph_r <= (st_r == S_H);

  // update cells: Hz cell for the H sweep, Ex and Ey cells for the E sweep
  logic signed [32:0] dexn, deyx, dhy, dhx;
  assign dexn = 33'(exn_r) - 33'(ex0_r);
  assign deyx = 33'(eyx_r) - 33'(ey0_r);
  assign dhy = 33'(hz0_r) - 33'(hzn_r);
  assign dhx = 33'(hz0_r) - 33'(hzx_r);

  logic hv, xv, yv, hs, xs, ys;
  logic [AW-1:0] ha, xa, ya;
  logic signed [31:0] hval, xval, yval;
  fdtd_cell u_hz (.clk, .vld_in(pv_r & ph_r), .addr_in(pa_r), .base_in(hz0_r),
    .d_a(dexn), .d_b(deyx), .c_a(chy_r), .c_b(chx_r), .neg_b(1'b1),
    .vld_out(hv), .addr_out(ha), .val_out(hval), .sat_out(hs));
  fdtd_cell u_ex (.clk, .vld_in(pv_r & !ph_r), .addr_in(pa_r), .base_in(ex0_r),
    .d_a(dhy), .d_b(33'(jx_r)), .c_a(cey_r), .c_b(csrc_r), .neg_b(1'b1),
    .vld_out(xv), .addr_out(xa), .val_out(xval), .sat_out(xs));
  fdtd_cell u_ey (.clk, .vld_in(pv_r & !ph_r), .addr_in(pa_r), .base_in(ey0_r),
    .d_a(-dhx), .d_b(33'(jy_r)), .c_a(cex_r), .c_b(csrc_r), .neg_b(1'b1),
    .vld_out(yv), .addr_out(ya), .val_out(yval), .sat_out(ys));

  // memory writes
  logic acc;
  assign acc = start && !busy;
  always_ff @(posedge clk) begin
    if (st_r == S_CLR) begin
      ex_m[sa] <= '0; ey_m[sa] <= '0; hz_m[sa] <= '0;
      jx_m[sa] <= '0; jy_m[sa] <= '0;
    end else if (acc && in_req_type == fdtd_pkg::REQ_WR_FIELD) begin
      ex_m[{in_cell_y, in_cell_x}] <= in_ex_in;
      ey_m[{in_cell_y, in_cell_x}] <= in_ey_in;
      hz_m[{in_cell_y, in_cell_x}] <= in_hz_in;
    end else if (acc && in_req_type == fdtd_pkg::REQ_WR_CUR) begin
      jx_m[{in_cell_y, in_cell_x}] <= in_jx_in;
      jy_m[{in_cell_y, in_cell_x}] <= in_jy_in;
    end else begin
      if (hv) hz_m[ha] <= hval;
      if (xv) ex_m[xa] <= xval;
      if (yv) ey_m[ya] <= yval;
    end
  end

  // sequencer: each sweep runs on past its last cell to drain the read and cell stages
  localparam logic [AW:0] DRAIN = (AW+1)'(fdtd_pkg::NCELLS + 4);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; cnt_r <= '0; sat_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == (AW+1)'(fdtd_pkg::NCELLS - 1)) begin
            st_r <= S_IDLE; cnt_r <= '0;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (in_req_type == fdtd_pkg::REQ_READ) st_r <= S_RD;
            else if (in_req_type == fdtd_pkg::REQ_STEP) begin
              st_r <= S_H; cnt_r <= '0; sat_r <= 1'b0;
            end
          end
        end
        S_RD: st_r <= S_IDLE;
        S_H, S_E: begin
          if (hv && hs) sat_r <= 1'b1;
          if ((xv && xs) || (yv && ys)) sat_r <= 1'b1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DRAIN) begin
            cnt_r <= '0;
            st_r <= (st_r == S_H) ? S_E : S_DONE;
          end
        end
        S_DONE: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // result output
  always_comb begin
    out_valid = (st_r == S_RD) || (st_r == S_DONE);
    out_result_kind = (st_r == S_DONE);
    out_saturated = sat_r;
    if (st_r == S_RD) begin
      out_ex_out = ex0_r; out_ey_out = ey0_r; out_hz_out = hz0_r;
    end else begin
      out_ex_out = '0; out_ey_out = '0; out_hz_out = '0;
    end
  end

  `ASSERT_CLK(a_no_accept_busy, clk, rst_n, busy |-> !acc, "item accepted while busy")
  `ASSERT_CLK(a_done_after_e, clk, rst_n, (st_r == S_DONE) |-> $past(st_r) == S_E, "bad done")
  `ASSERT_CLK(a_no_cell_idle, clk, rst_n, (st_r == S_IDLE) |-> !(hv || xv || yv), "cell busy idle")
  `ASSERT_ALWAYS(a_cfg_ready, clk, cfg_ready, "cfg not ready")
endmodule
`default_nettype wire
